/* sv/rrq_pkg.sv */
`timescale 1ns / 1ps
// Shared types, codes and defaults for the round-robin ready queue.
package rrq_pkg;

	localparam int LIST_DEPTH_DEF = 16;
	localparam int ID_BITS_DEF    = 16;

	localparam logic [1:0] MODE_ADD    = 2'd0;
	localparam logic [1:0] MODE_NEXT   = 2'd1;
	localparam logic [1:0] MODE_REMOVE = 2'd2;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_FULL     = 2'd1;
	localparam logic [1:0] ST_EMPTY    = 2'd2;
	localparam logic [1:0] ST_NOTFOUND = 2'd3;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CMP,
		S_APPLY
	} state_t;

	typedef struct packed {
		logic shift;
		logic load;
	} cell_ctl_t;

endpackage

/* sv/rrq_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces for request and response words.
interface rrq_req_if #(
	parameter int ID_BITS = rrq_pkg::ID_BITS_DEF
);
	logic               valid;
	logic               ready;
	logic [1:0]         mode;
	logic [ID_BITS-1:0] task_id;

	modport source (output valid, output mode, output task_id, input ready);
	modport sink   (input valid, input mode, input task_id, output ready);
endinterface

interface rrq_rsp_if #(
	parameter int ID_BITS  = rrq_pkg::ID_BITS_DEF,
	parameter int CNT_BITS = $clog2(rrq_pkg::LIST_DEPTH_DEF + 1)
);
	logic                valid;
	logic                ready;
	logic [ID_BITS-1:0]  current_id;
	logic                current_valid;
	logic                start_task;
	logic [CNT_BITS-1:0] entry_count;
	logic [1:0]          status;

	modport source (output valid, output current_id, output current_valid,
		output start_task, output entry_count, output status, input ready);
	modport sink   (input valid, input current_id, input current_valid,
		input start_task, input entry_count, input status, output ready);
endinterface

/* sv/rrq_cell.sv */
`timescale 1ns / 1ps
// One list slot: holds an id, compares it, shifts from its right neighbour or loads.
module rrq_cell #(
	parameter int ID_BITS = rrq_pkg::ID_BITS_DEF
) (
	input  logic               clk,
	input  rrq_pkg::cell_ctl_t ctl,
	input  logic [ID_BITS-1:0] cmp_id,
	input  logic [ID_BITS-1:0] right_id,
	input  logic [ID_BITS-1:0] load_id,
	output logic [ID_BITS-1:0] entry_id,
	output logic               match
);

	logic [ID_BITS-1:0] entry_q;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			entry_q <= load_id;
		end else if (ctl.shift) begin
			entry_q <= right_id;
		end
	end

	assign entry_id = entry_q;
	assign match    = (entry_q == cmp_id);

endmodule

/* sv/round_robin_ready_queue.sv */
`timescale 1ns / 1ps
// Top level of the round-robin ready queue: cell row, sequencer and response register.
//
// Request words on req carry a mode (add at tail, rotate and run next, remove) and a task
// id; every request gives exactly one response word on rsp with the current task id, its
// valid flag, a start pulse, the entry count after the request and a status code.
// The list is a row of cells, one per slot; each cell compares its id against the request
// and shifts from its right neighbour, so rotate and remove close up in one step.
// A request passes through a compare step, which registers the per-cell match vector, and an
// apply step, which picks the last match, updates the cells and loads the response register.
// A new request is taken in the cycle the previous one completes, during its apply step; no
// request is taken while one is in its compare step.
// Reset clears the entry count, current task and sequencer; slot contents need no clearing
// because only slots below the count are ever read.
// When rsp stalls, the response register holds its word; the following request is
// still taken and compared, then waits in its apply step until the register frees.
module round_robin_ready_queue #(
	parameter int LIST_DEPTH = rrq_pkg::LIST_DEPTH_DEF,
	parameter int ID_BITS    = rrq_pkg::ID_BITS_DEF,
	parameter int CNT_BITS   = $clog2(LIST_DEPTH + 1)
) (
	input logic        clk,
	input logic        arst_n,
	rrq_req_if.sink    req,
	rrq_rsp_if.source  rsp
);

	rrq_pkg::state_t state_q, state_d;

	logic [1:0]            mode_s1;
	logic [ID_BITS-1:0]    id_s1;
	logic [LIST_DEPTH-1:0] match_q;
	logic [LIST_DEPTH-1:0] match_raw;
	logic [LIST_DEPTH-1:0] above;
	logic [CNT_BITS-1:0]   count_q, count_d;
	logic [ID_BITS-1:0]    cur_q, cur_d;
	logic                  set_q, set_d;
	logic                  start_d;
	logic [1:0]            status_d;

	logic                  rsp_valid_q;
	logic [ID_BITS-1:0]    rsp_id_q;
	logic                  rsp_cv_q;
	logic                  rsp_start_q;
	logic [CNT_BITS-1:0]   rsp_count_q;
	logic [1:0]            rsp_status_q;

	logic [ID_BITS-1:0]    ent [LIST_DEPTH];
	rrq_pkg::cell_ctl_t    ctl [LIST_DEPTH];
	logic [ID_BITS-1:0]    load_data;

	logic req_acc, rsp_free, apply_en;
	logic full, empty, found, head_hit;
	logic [CNT_BITS-1:0] last_idx;

	assign req_acc  = req.valid && req.ready;
	assign rsp_free = !rsp_valid_q || rsp.ready;
	assign apply_en = (state_q == rrq_pkg::S_APPLY) && rsp_free;

	// cell row
	for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
		logic [ID_BITS-1:0] right;
		if (g == LIST_DEPTH - 1) begin : g_tail
			assign right = ent[g];
		end else begin : g_mid
			assign right = ent[g+1];
		end
		rrq_cell #(.ID_BITS(ID_BITS)) u_cell (
			.clk      (clk),
			.ctl      (ctl[g]),
			.cmp_id   (id_s1),
			.right_id (right),
			.load_id  (load_data),
			.entry_id (ent[g]),
			.match    (match_raw[g])
		);
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rrq_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rrq_pkg::S_IDLE: begin
				if (req_acc) state_d = rrq_pkg::S_CMP;
			end
			rrq_pkg::S_CMP: begin
				state_d = rrq_pkg::S_APPLY;
			end
			rrq_pkg::S_APPLY: begin
				if (rsp_free) state_d = req_acc ? rrq_pkg::S_CMP : rrq_pkg::S_IDLE;
			end
			default: state_d = rrq_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		req.ready = (state_q == rrq_pkg::S_IDLE) || apply_en;
	end

	// request and match registers
	always_ff @(posedge clk) begin
		if (req_acc) begin
			mode_s1 <= req.mode;
			id_s1   <= req.task_id;
		end
		if (state_q == rrq_pkg::S_CMP) begin
			for (int i = 0; i < LIST_DEPTH; i++) begin
				match_q[i] <= match_raw[i] && (CNT_BITS'(i) < count_q);
			end
		end
	end

	// matches beyond each slot; the last match is the slot with none beyond it
	always_comb begin
		for (int i = 0; i < LIST_DEPTH; i++) begin
			above[i] = |(match_q >> (i + 1));
		end
	end

	assign full     = (count_q == CNT_BITS'(LIST_DEPTH));
	assign empty    = (count_q == '0);
	assign found    = |match_q;
	assign head_hit = match_q[0] && !above[0];
	assign last_idx = count_q - CNT_BITS'(1);
	assign load_data = (mode_s1 == rrq_pkg::MODE_ADD) ? id_s1 : ent[0];

	always_comb begin
		for (int i = 0; i < LIST_DEPTH; i++) begin
			ctl[i] = '0;
			if (apply_en) begin
				case (mode_s1)
					rrq_pkg::MODE_ADD: begin
						ctl[i].load = !full && (CNT_BITS'(i) == count_q);
					end
					rrq_pkg::MODE_NEXT: begin
						ctl[i].shift = !empty && (CNT_BITS'(i + 1) < count_q);
						ctl[i].load  = !empty && (CNT_BITS'(i) == last_idx);
					end
					rrq_pkg::MODE_REMOVE: begin
						ctl[i].shift = !empty && found && !above[i]
							&& (CNT_BITS'(i + 1) < count_q);
					end
					default: ctl[i] = '0;
				endcase
			end
		end
	end

	// result of the request
	always_comb begin
		count_d  = count_q;
		cur_d    = cur_q;
		set_d    = set_q;
		start_d  = 1'b0;
		status_d = rrq_pkg::ST_OK;
		case (mode_s1)
			rrq_pkg::MODE_ADD: begin
				if (full) status_d = rrq_pkg::ST_FULL;
				else count_d = count_q + CNT_BITS'(1);
			end
			rrq_pkg::MODE_NEXT: begin
				if (empty) begin
					status_d = rrq_pkg::ST_EMPTY;
				end else begin
					cur_d   = (count_q > CNT_BITS'(1)) ? ent[1] : ent[0];
					set_d   = 1'b1;
					start_d = 1'b1;
				end
			end
			rrq_pkg::MODE_REMOVE: begin
				if (empty) begin
					status_d = rrq_pkg::ST_EMPTY;
				end else if (!found) begin
					status_d = rrq_pkg::ST_NOTFOUND;
				end else begin
					count_d = last_idx;
					if (head_hit) begin
						if (count_q > CNT_BITS'(1)) begin
							cur_d   = ent[1];
							set_d   = 1'b1;
							start_d = 1'b1;
						end else begin
							set_d = 1'b0;
						end
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			cur_q       <= '0;
			set_q       <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (apply_en) begin
				count_q     <= count_d;
				cur_q       <= cur_d;
				set_q       <= set_d;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (apply_en) begin
			rsp_id_q     <= cur_d;
			rsp_cv_q     <= set_d && (count_d != '0);
			rsp_start_q  <= start_d;
			rsp_count_q  <= count_d;
			rsp_status_q <= status_d;
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.current_id    = rsp_id_q;
	assign rsp.current_valid = rsp_cv_q;
	assign rsp.start_task    = rsp_start_q;
	assign rsp.entry_count   = rsp_count_q;
	assign rsp.status        = rsp_status_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_BITS'(LIST_DEPTH))
		else $error("entry count beyond list depth");

	a_rsp_from_apply: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == rrq_pkg::S_APPLY))
		else $error("response word without apply step");

	a_accept_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc |=> state_q == rrq_pkg::S_CMP)
		else $error("accepted request not compared");

	a_start_valid: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_start_q |-> rsp_cv_q && rsp_status_q == rrq_pkg::ST_OK)
		else $error("start pulse without valid current task");

endmodule
